// ===== hw/rtl/int_to_ascii_digits_macros.svh =====
// assertion helpers for int_to_ascii_digits.sv, the one file that checks itself
`ifndef INT_TO_ASCII_DIGITS_MACROS_SVH
`define INT_TO_ASCII_DIGITS_MACROS_SVH

// same-cycle implication, sampled on aclk, quiet during reset
`define I2A_ASSERT_IMPL(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("i2a assertion failed");

// next-cycle implication, sampled on aclk, quiet during reset
`define I2A_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("i2a assertion failed");

`endif

// ===== hw/rtl/i2a_pkg.sv =====
`timescale 1ns / 1ps

package i2a_pkg;

    localparam int I2A_MAX_PAD_DEF = 16;
    localparam int I2A_BIN_W       = 32;
    localparam int I2A_PAD_W       = 5;
    // compare width for the pad limit, covers a limit of up to 32
    localparam int I2A_PAD_CMP_W   = 6;
    localparam int I2A_NUM_DEC     = 10;
    localparam int I2A_NUM_HEX     = 8;
    localparam int I2A_BCD_W       = 4 * I2A_NUM_DEC;
    localparam int I2A_CHAR_W      = 8;

    localparam logic [I2A_CHAR_W-1:0] I2A_ASCII_ZERO  = 8'h30;
    localparam logic [I2A_CHAR_W-1:0] I2A_ASCII_A     = 8'h41;
    localparam logic [I2A_CHAR_W-1:0] I2A_ASCII_MINUS = 8'h2D;

    typedef struct packed {
        logic load;
        logic shift;
        logic start_emit;
        logic emit;
    } i2a_cmd_t;

    typedef struct packed {
        logic is_hex;
        logic bits_done;
        logic out_free;
        logic emit_last;
    } i2a_stat_t;

    function automatic logic [I2A_CHAR_W-1:0] digit_char(input logic [3:0] d);
        if (d > 4'd9) begin
            return I2A_ASCII_A + {4'b0, d} - 8'd10;
        end
        return I2A_ASCII_ZERO + {4'b0, d};
    endfunction

endpackage

// ===== hw/rtl/int_to_ascii_digits.sv =====
// throughput: one character per cycle while m_tready is high; a new word is taken only after the last character
// decimal conversion runs the shift-add-3 loop, one bit of the word per cycle; hex needs no conversion
// a word's characters are the sign plus the digit count, at most MAX_PAD + 1 or 11 unpadded
// reset: synchronous, active low; clears the sequencer and the output valid flag
`timescale 1ns / 1ps

`include "int_to_ascii_digits_macros.svh"

module int_to_ascii_digits
    import i2a_pkg::*;
#(
    parameter int MAX_PAD = I2A_MAX_PAD_DEF   // largest honoured pad width, 1 to 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    // input word channel
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,    // [31:0] value, [36:32] pad_width, [39:37] zero
    input  logic [0:0]  s_tuser,    // [0] op: 0 signed decimal, 1 hex
    // character channel
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [7:0]  m_tdata,    // [7:0] ascii_char
    output logic        m_tlast     // last character of the word
);

    i2a_cmd_t  cmd;
    i2a_stat_t stat;

    // sequencer: idle, bcd conversion, length setup, character emission
    i2a_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    // magnitude, bcd shift register, digit index and the output register
    i2a_datapath #(
        .MAX_PAD (MAX_PAD)
    ) u_dp (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_op     (s_tuser[0]),
        .in_value  (s_tdata[I2A_BIN_W-1:0]),
        .in_pad    (s_tdata[I2A_BIN_W +: I2A_PAD_W]),
        .cmd       (cmd),
        .stat      (stat),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .out_char  (m_tdata),
        .out_last  (m_tlast)
    );

    // one word in flight: an accepted word closes the input side
    `I2A_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready)
    // while a character other than the final one waits, no new word is taken
    `I2A_ASSERT_IMPL(a_no_accept_mid_word, m_tvalid && !m_tlast, !s_tready)
    // a minus sign is never the final character
    `I2A_ASSERT_IMPL(a_sign_not_last, m_tvalid && (m_tdata == I2A_ASCII_MINUS), !m_tlast)

endmodule

// ===== hw/rtl/i2a_ctrl.sv =====
`timescale 1ns / 1ps

module i2a_ctrl
    import i2a_pkg::*;
(
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_tvalid,
    output logic      s_tready,
    input  i2a_stat_t stat,
    output i2a_cmd_t  cmd
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CONV = 2'd1;
    localparam logic [1:0] ST_PREP = 2'd2;
    localparam logic [1:0] ST_EMIT = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_CONV;
                end
            end
            ST_CONV: begin
                if (stat.is_hex) begin
                    state_next = ST_PREP;
                end else begin
                    cmd.shift = 1'b1;
                    if (stat.bits_done) begin
                        state_next = ST_PREP;
                    end
                end
            end
            ST_PREP: begin
                cmd.start_emit = 1'b1;
                state_next     = ST_EMIT;
            end
            ST_EMIT: begin
                if (stat.out_free) begin
                    cmd.emit = 1'b1;
                    if (stat.emit_last) begin
                        state_next = ST_IDLE;
                    end
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== hw/rtl/i2a_datapath.sv =====
`timescale 1ns / 1ps

module i2a_datapath
    import i2a_pkg::*;
#(
    parameter int MAX_PAD = I2A_MAX_PAD_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  in_op,
    input  logic [I2A_BIN_W-1:0]  in_value,
    input  logic [I2A_PAD_W-1:0]  in_pad,
    input  i2a_cmd_t              cmd,
    output i2a_stat_t             stat,
    output logic                  out_valid,
    input  logic                  out_ready,
    output logic [I2A_CHAR_W-1:0] out_char,
    output logic                  out_last
);

    localparam int DMAX = (MAX_PAD > I2A_NUM_DEC) ? MAX_PAD : I2A_NUM_DEC;
    localparam int IW   = $clog2(DMAX);
    localparam int CW   = $clog2(DMAX + 1);
    localparam int BCW  = $clog2(I2A_BIN_W);

    logic                  op_reg;
    logic                  neg_reg;
    logic                  sign_pend_reg;
    logic [CW-1:0]         pad_reg;
    logic [I2A_BIN_W-1:0]  mag_reg;
    logic [I2A_BCD_W-1:0]  bcd_reg;
    logic [BCW-1:0]        bit_cnt_reg;
    logic [IW-1:0]         idx_reg;
    logic                  out_valid_reg;
    logic [I2A_CHAR_W-1:0] out_char_reg;
    logic                  out_last_reg;

    logic                     in_neg;
    logic [I2A_PAD_CMP_W-1:0] pad_wide;
    logic [I2A_PAD_CMP_W-1:0] pad_sat;
    logic [I2A_BCD_W-1:0]     bcd_adj;
    logic [3:0]               nat_cnt;
    logic [CW-1:0]            n_digits;
    logic [3:0]               sel_digit;
    logic                     out_free;

    assign in_neg   = !in_op && in_value[I2A_BIN_W-1];
    assign pad_wide = {{(I2A_PAD_CMP_W-I2A_PAD_W){1'b0}}, in_pad};
    assign pad_sat  = (pad_wide > I2A_PAD_CMP_W'(MAX_PAD)) ? I2A_PAD_CMP_W'(MAX_PAD) : pad_wide;

    // add-3 correction of every bcd digit before the shift
    always_comb begin
        for (int k = 0; k < I2A_NUM_DEC; k++) begin
            if (bcd_reg[k*4 +: 4] >= 4'd5) begin
                bcd_adj[k*4 +: 4] = bcd_reg[k*4 +: 4] + 4'd3;
            end else begin
                bcd_adj[k*4 +: 4] = bcd_reg[k*4 +: 4];
            end
        end
    end

    // natural length: highest nonzero digit, at least one
    always_comb begin
        nat_cnt = 4'd1;
        for (int k = 1; k < I2A_NUM_DEC; k++) begin
            if (bcd_reg[k*4 +: 4] != 4'd0) begin
                nat_cnt = 4'(k + 1);
            end
        end
    end

    assign n_digits = (pad_reg != '0) ? pad_reg : CW'(nat_cnt);

    // digit positions above the stored ones read as zero
    always_comb begin
        sel_digit = 4'd0;
        for (int k = 0; k < I2A_NUM_DEC; k++) begin
            if (idx_reg == IW'(k)) begin
                sel_digit = bcd_reg[k*4 +: 4];
            end
        end
    end

    assign out_free = !out_valid_reg || out_ready;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            op_reg      <= in_op;
            neg_reg     <= in_neg;
            pad_reg     <= CW'(pad_sat);
            mag_reg     <= in_neg ? (~in_value + 1'b1) : in_value;
            bit_cnt_reg <= BCW'(I2A_BIN_W - 1);
            if (in_op) begin
                bcd_reg <= {{(I2A_BCD_W-I2A_BIN_W){1'b0}}, in_value};
            end else begin
                bcd_reg <= '0;
            end
        end else if (cmd.shift) begin
            bcd_reg     <= {bcd_adj[I2A_BCD_W-2:0], mag_reg[I2A_BIN_W-1]};
            mag_reg     <= {mag_reg[I2A_BIN_W-2:0], 1'b0};
            bit_cnt_reg <= bit_cnt_reg - 1'b1;
        end
        if (cmd.start_emit) begin
            idx_reg <= IW'(n_digits - 1'b1);
        end else if (cmd.emit && !sign_pend_reg) begin
            idx_reg <= idx_reg - 1'b1;
        end
        if (cmd.emit) begin
            if (sign_pend_reg) begin
                out_char_reg <= I2A_ASCII_MINUS;
                out_last_reg <= 1'b0;
            end else begin
                out_char_reg <= digit_char(sel_digit);
                out_last_reg <= (idx_reg == '0);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            sign_pend_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            if (cmd.start_emit) begin
                sign_pend_reg <= neg_reg;
            end else if (cmd.emit) begin
                sign_pend_reg <= 1'b0;
            end
            if (cmd.emit) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign stat.is_hex    = op_reg;
    assign stat.bits_done = (bit_cnt_reg == '0);
    assign stat.out_free  = out_free;
    assign stat.emit_last = !sign_pend_reg && (idx_reg == '0);

    assign out_valid = out_valid_reg;
    assign out_char  = out_char_reg;
    assign out_last  = out_last_reg;

endmodule
